// ===== design/rpnh_pkg.sv =====
// Shared types and fixed widths for the ray / polygon nearest-hit block.
package rpnh_pkg;

   localparam int COORD_BITS = 16;               // vertex and ray coordinates
   localparam int DIFF_W     = COORD_BITS + 1;   // coordinate differences
   localparam int MOP_W      = DIFF_W + 1;       // shared multiplier operand
   localparam int PROD_W     = 2 * MOP_W;        // shared multiplier product
   localparam int CROSS_W    = 2 * DIFF_W + 1;   // signed cross product sums
   localparam int MAG_W      = CROSS_W - 1;      // their magnitudes
   localparam int HALF_W     = MAG_W / 2;        // half of a magnitude
   localparam int ACC_W      = 2 * MAG_W + 2;    // wide compare accumulator
   localparam int SCALE_W    = MAG_W + DIFF_W - 1; // un * |dir|
   localparam int FRAC_BITS  = 8;
   localparam int NUM_W      = SCALE_W + FRAC_BITS + 2; // rounded dividend
   localparam int DEN_W      = MAG_W + 1;        // 2 * den
   localparam int OUT_W      = 24;
   localparam int QSAT_W     = OUT_W + 2;        // clamped quotient
   localparam int SUM_W      = OUT_W + 3;        // start*256 +/- quotient
   localparam int STEP_W     = 4;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_REPLACE = 2'd1,
      CMD_CAST    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // what to do with a product once it leaves the multiplier register
   typedef enum logic [3:0] {
      ACC_NONE,
      ACC_DEN_SET,
      ACC_DEN_SUB,
      ACC_UN_SET,
      ACC_UN_SUB,
      ACC_TN_SET,
      ACC_TN_SUB,
      ACC_ADD_L0,
      ACC_ADD_L1,
      ACC_ADD_L2,
      ACC_SUB_L0,
      ACC_SUB_L1,
      ACC_SUB_L2
   } acc_op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== design/ray_polygon_nearest_hit.sv =====
// Top level: vertex store, edge sequencer, shared multiplier and divider.
//
//  channel | dir | tdata (low bit up)                 | tuser
//  req     | in  | pt_x, pt_y, end_x, end_y (16 each)  | opcode[1:0]
//  rsp     | out | hit_x, hit_y (24 each)              | hit, op_error
//
// Append, replace and unused opcodes go straight from idle to the response.
// A cast reads, loads, runs six products through the shared multiplier and
// checks each edge; each hit that must be compared against the best so far
// adds eight more products, and the nearest hit then adds two products and a division per axis.
// Reset clears the vertex count; stored vertices are undefined until written.
// One transaction in flight; the result register frees the input side while
// a result waits, and the sequencer holds only when a second result is ready.
module ray_polygon_nearest_hit
   import rpnh_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pt_x, pt_y, end_x, end_y
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // hit_x, hit_y
   output logic [1:0]  rsp_tuser    // hit, op_error
);

   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int CW2  = 2 * COORD_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE_RD, ST_EDGE_LD, ST_EDGE_MUL, ST_EDGE_CHK, ST_EDGE_CMP,
      ST_EDGE_DEC, ST_FINISH, ST_HIT_MUL, ST_HIT_DIV, ST_HIT_WAIT, ST_RESP
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNTW-1:0]           cnt_ff, cnt_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [STEP_W-1:0]         st_ff, st_in;
   logic                      axis_ff, axis_in;
   logic                      found_ff, found_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DIFF_W-1:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic signed [DIFF_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CROSS_W-1:0] den_ff, den_in, un_ff, un_in, tn_ff, tn_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [MAG_W-1:0]          cu_ff, cu_in, cd_ff, cd_in, bu_ff, bu_in, bd_ff, bd_in;
   logic                      hit_ff, hit_in, err_ff, err_in;
   logic signed [OUT_W-1:0]   hx_ff, hx_in, hy_ff, hy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [47:0]               rsp_data_ff, rsp_data_in;
   logic [1:0]                rsp_user_ff, rsp_user_in;

   logic                      accept;
   cmd_type                   cmd;
   logic                      full, empty, last_edge;
   logic [AW-1:0]             nxt_idx;

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [CW2-1:0]            rd_a, rd_b;

   logic signed [MOP_W-1:0]   mul_a, mul_b;
   acc_op_type                mul_op, prod_op;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   prod_x;

   logic                      div_start;
   logic [NUM_W-1:0]          div_num, div_quo;
   div_stat_type              div_stat;

   logic signed [CROSS_W-1:0] dn, un_n, tn_n;
   logic                      edge_ok;
   logic [DIFF_W-1:0]         mdir;
   logic                      dneg;
   logic [QSAT_W-1:0]         qc;
   logic signed [SUM_W-1:0]   base, vsum;
   logic signed [OUT_W-1:0]   vsat;
   logic signed [COORD_BITS-1:0] ax, ay, bx, by;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd        = cmd_type'(req_tuser);
   assign full       = (cnt_ff == CNTW'(MAX_VERTICES));
   assign empty      = (cnt_ff == '0);
   assign last_edge  = ((CNTW'(idx_ff) + CNTW'(1)) == cnt_ff);
   assign nxt_idx    = last_edge ? '0 : AW'(idx_ff + AW'(1));

   assign mem_we    = accept && (((cmd == CMD_APPEND) && !full) ||
                                 ((cmd == CMD_REPLACE) && !empty));
   assign mem_waddr = (cmd == CMD_APPEND) ? AW'(cnt_ff) : AW'(cnt_ff - CNTW'(1));

   rpnh_vstore #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vstore (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (req_tdata[CW2-1:0]),
      .raddr_a (idx_ff),
      .raddr_b (nxt_idx),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   rpnh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .acc_op  (mul_op),
      .prod    (prod),
      .prod_op (prod_op)
   );

   rpnh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({bd_ff, 1'b0}),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   assign ax = rd_a[COORD_BITS-1:0];
   assign ay = rd_a[CW2-1:COORD_BITS];
   assign bx = rd_b[COORD_BITS-1:0];
   assign by = rd_b[CW2-1:COORD_BITS];

   // direction of the axis being resolved
   assign dneg = axis_ff ? dy_ff[DIFF_W-1] : dx_ff[DIFF_W-1];
   assign mdir = axis_ff ? (dneg ? DIFF_W'(-dy_ff) : dy_ff)
                         : (dneg ? DIFF_W'(-dx_ff) : dx_ff);

   assign div_start = (state_ff == ST_HIT_DIV);
   assign div_num   = NUM_W'({acc_ff[SCALE_W-1:0], {(FRAC_BITS + 1){1'b0}}})
                    + NUM_W'(bd_ff) - NUM_W'(dneg);

   // start*256 -/+ rounded quotient, saturated
   always_comb begin
      qc   = (|div_quo[NUM_W-1:QSAT_W-1]) ? {1'b1, {(QSAT_W-1){1'b0}}}
                                         : div_quo[QSAT_W-1:0];
      base = SUM_W'(axis_ff ? py_ff : px_ff) <<< FRAC_BITS;
      vsum = dneg ? base - $signed({1'b0, qc}) : base + $signed({1'b0, qc});
      if (vsum > SUM_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
         vsat = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (vsum < SUM_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
         vsat = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         vsat = vsum[OUT_W-1:0];
      end
   end

   // edge test on the sign-normalised cross products
   always_comb begin
      dn      = den_ff[CROSS_W-1] ? -den_ff : den_ff;
      un_n    = den_ff[CROSS_W-1] ? -un_ff  : un_ff;
      tn_n    = den_ff[CROSS_W-1] ? -tn_ff  : tn_ff;
      edge_ok = (den_ff != '0) && !un_n[CROSS_W-1] && !tn_n[CROSS_W-1] && (tn_n <= dn);
   end

   // multiplier operand schedule
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_op = ACC_NONE;
      unique case (state_ff)
         ST_EDGE_MUL: begin
            case (st_ff)
               4'd0: begin mul_a = MOP_W'(dx_ff); mul_b = MOP_W'(gy_ff); mul_op = ACC_DEN_SET; end
               4'd1: begin mul_a = MOP_W'(dy_ff); mul_b = MOP_W'(gx_ff); mul_op = ACC_DEN_SUB; end
               4'd2: begin mul_a = MOP_W'(qx_ff); mul_b = MOP_W'(gy_ff); mul_op = ACC_UN_SET;  end
               4'd3: begin mul_a = MOP_W'(qy_ff); mul_b = MOP_W'(gx_ff); mul_op = ACC_UN_SUB;  end
               4'd4: begin mul_a = MOP_W'(qx_ff); mul_b = MOP_W'(dy_ff); mul_op = ACC_TN_SET;  end
               4'd5: begin mul_a = MOP_W'(qy_ff); mul_b = MOP_W'(dx_ff); mul_op = ACC_TN_SUB;  end
               default: ;
            endcase
         end
         ST_EDGE_CMP: begin
            // cand_un*best_den - best_un*cand_den from 17-bit halves
            case (st_ff)
               4'd0: begin mul_a = {1'b0, cu_ff[MAG_W-1:HALF_W]}; mul_b = {1'b0, bd_ff[MAG_W-1:HALF_W]}; mul_op = ACC_ADD_L2; end
               4'd1: begin mul_a = {1'b0, cu_ff[MAG_W-1:HALF_W]}; mul_b = {1'b0, bd_ff[HALF_W-1:0]};     mul_op = ACC_ADD_L1; end
               4'd2: begin mul_a = {1'b0, cu_ff[HALF_W-1:0]};     mul_b = {1'b0, bd_ff[MAG_W-1:HALF_W]}; mul_op = ACC_ADD_L1; end
               4'd3: begin mul_a = {1'b0, cu_ff[HALF_W-1:0]};     mul_b = {1'b0, bd_ff[HALF_W-1:0]};     mul_op = ACC_ADD_L0; end
               4'd4: begin mul_a = {1'b0, bu_ff[MAG_W-1:HALF_W]}; mul_b = {1'b0, cd_ff[MAG_W-1:HALF_W]}; mul_op = ACC_SUB_L2; end
               4'd5: begin mul_a = {1'b0, bu_ff[MAG_W-1:HALF_W]}; mul_b = {1'b0, cd_ff[HALF_W-1:0]};     mul_op = ACC_SUB_L1; end
               4'd6: begin mul_a = {1'b0, bu_ff[HALF_W-1:0]};     mul_b = {1'b0, cd_ff[MAG_W-1:HALF_W]}; mul_op = ACC_SUB_L1; end
               4'd7: begin mul_a = {1'b0, bu_ff[HALF_W-1:0]};     mul_b = {1'b0, cd_ff[HALF_W-1:0]};     mul_op = ACC_SUB_L0; end
               default: ;
            endcase
         end
         ST_HIT_MUL: begin
            case (st_ff)
               4'd0: begin mul_a = {1'b0, bu_ff[MAG_W-1:HALF_W]}; mul_b = {1'b0, mdir}; mul_op = ACC_ADD_L1; end
               4'd1: begin mul_a = {1'b0, bu_ff[HALF_W-1:0]};     mul_b = {1'b0, mdir}; mul_op = ACC_ADD_L0; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign prod_x = ACC_W'(prod);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      st_in        = st_ff;
      axis_in      = axis_ff;
      found_in     = found_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      den_in       = den_ff;
      un_in        = un_ff;
      tn_in        = tn_ff;
      acc_in       = acc_ff;
      cu_in        = cu_ff;
      cd_in        = cd_ff;
      bu_in        = bu_ff;
      bd_in        = bd_ff;
      hit_in       = hit_ff;
      err_in       = err_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // product leaving the multiplier register
      case (prod_op)
         ACC_DEN_SET: den_in = CROSS_W'(prod);
         ACC_DEN_SUB: den_in = den_ff - CROSS_W'(prod);
         ACC_UN_SET:  un_in  = CROSS_W'(prod);
         ACC_UN_SUB:  un_in  = un_ff - CROSS_W'(prod);
         ACC_TN_SET:  tn_in  = CROSS_W'(prod);
         ACC_TN_SUB:  tn_in  = tn_ff - CROSS_W'(prod);
         ACC_ADD_L0:  acc_in = acc_ff + prod_x;
         ACC_ADD_L1:  acc_in = acc_ff + (prod_x <<< HALF_W);
         ACC_ADD_L2:  acc_in = acc_ff + (prod_x <<< (2 * HALF_W));
         ACC_SUB_L0:  acc_in = acc_ff - prod_x;
         ACC_SUB_L1:  acc_in = acc_ff - (prod_x <<< HALF_W);
         ACC_SUB_L2:  acc_in = acc_ff - (prod_x <<< (2 * HALF_W));
         default: ;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in  = req_tdata[15:0];
               py_in  = req_tdata[31:16];
               dx_in  = DIFF_W'(signed'(req_tdata[47:32])) - DIFF_W'(signed'(req_tdata[15:0]));
               dy_in  = DIFF_W'(signed'(req_tdata[63:48])) - DIFF_W'(signed'(req_tdata[31:16]));
               hit_in = 1'b0;
               err_in = 1'b0;
               hx_in  = '0;
               hy_in  = '0;
               state_in = ST_RESP;
               unique case (cmd)
                  CMD_APPEND: begin
                     if (full) err_in = 1'b1;
                     else      cnt_in = cnt_ff + CNTW'(1);
                  end
                  CMD_REPLACE: begin
                     if (empty) err_in = 1'b1;
                  end
                  CMD_CAST: begin
                     found_in = 1'b0;
                     idx_in   = '0;
                     state_in = empty ? ST_FINISH : ST_EDGE_RD;
                  end
                  CMD_NONE: ;
               endcase
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_LD;
         ST_EDGE_LD: begin
            gx_in    = DIFF_W'(bx) - DIFF_W'(ax);
            gy_in    = DIFF_W'(by) - DIFF_W'(ay);
            qx_in    = DIFF_W'(ax) - DIFF_W'(px_ff);
            qy_in    = DIFF_W'(ay) - DIFF_W'(py_ff);
            st_in    = '0;
            state_in = ST_EDGE_MUL;
         end
         ST_EDGE_MUL: begin
            st_in = st_ff + STEP_W'(1);
            if (st_ff == STEP_W'(6)) state_in = ST_EDGE_CHK;
         end
         ST_EDGE_CHK: begin
            cu_in = un_n[MAG_W-1:0];
            cd_in = dn[MAG_W-1:0];
            if (edge_ok && found_ff) begin
               st_in    = '0;
               acc_in   = '0;
               state_in = ST_EDGE_CMP;
            end else begin
               if (edge_ok) begin
                  found_in = 1'b1;
                  bu_in    = un_n[MAG_W-1:0];
                  bd_in    = dn[MAG_W-1:0];
               end
               idx_in   = last_edge ? idx_ff : nxt_idx;
               state_in = last_edge ? ST_FINISH : ST_EDGE_RD;
            end
         end
         ST_EDGE_CMP: begin
            st_in = st_ff + STEP_W'(1);
            if (st_ff == STEP_W'(8)) state_in = ST_EDGE_DEC;
         end
         ST_EDGE_DEC: begin
            // strictly nearer only, so the earlier edge keeps a tie
            if (acc_ff[ACC_W-1]) begin
               bu_in = cu_ff;
               bd_in = cd_ff;
            end
            idx_in   = last_edge ? idx_ff : nxt_idx;
            state_in = last_edge ? ST_FINISH : ST_EDGE_RD;
         end
         ST_FINISH: begin
            if (found_ff) begin
               axis_in  = 1'b0;
               st_in    = '0;
               acc_in   = '0;
               state_in = ST_HIT_MUL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_HIT_MUL: begin
            st_in = st_ff + STEP_W'(1);
            if (st_ff == STEP_W'(2)) state_in = ST_HIT_DIV;
         end
         ST_HIT_DIV: state_in = ST_HIT_WAIT;
         ST_HIT_WAIT: begin
            if (div_stat.done) begin
               if (!axis_ff) begin
                  hx_in    = vsat;
                  axis_in  = 1'b1;
                  st_in    = '0;
                  acc_in   = '0;
                  state_in = ST_HIT_MUL;
               end else begin
                  hy_in    = vsat;
                  hit_in   = 1'b1;
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hy_ff, hx_ff};
               rsp_user_in  = {err_ff, hit_ff};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      st_ff       <= st_in;
      axis_ff     <= axis_in;
      found_ff    <= found_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      den_ff      <= den_in;
      un_ff       <= un_in;
      tn_ff       <= tn_in;
      acc_ff      <= acc_in;
      cu_ff       <= cu_in;
      cd_ff       <= cd_in;
      bu_ff       <= bu_in;
      bd_ff       <= bd_in;
      hit_ff      <= hit_in;
      err_ff      <= err_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction not taken up");

   a_hit_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("hit and op_error together");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HIT_DIV |-> !div_stat.busy)
      else $error("divider started while busy");

   a_cmp_needs_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EDGE_CMP |-> found_ff)
      else $error("compare without a best hit");

endmodule

// ===== design/rpnh_vstore.sv =====
// Vertex memory: one write port, two registered read ports.
module rpnh_vstore
   import rpnh_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  logic [2*COORD_BITS-1:0] wdata,
   input  logic [AW-1:0]           raddr_a,
   input  logic [AW-1:0]           raddr_b,
   output logic [2*COORD_BITS-1:0] rdata_a,
   output logic [2*COORD_BITS-1:0] rdata_b
);

   logic [2*COORD_BITS-1:0] mem [DEPTH];
   logic [2*COORD_BITS-1:0] rd_a_ff;
   logic [2*COORD_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

// ===== design/rpnh_mul.sv =====
// Shared signed multiplier with registered product and its accumulate tag.
module rpnh_mul
   import rpnh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [MOP_W-1:0]  op_a,
   input  logic signed [MOP_W-1:0]  op_b,
   input  acc_op_type               acc_op,
   output logic signed [PROD_W-1:0] prod,
   output acc_op_type               prod_op
);

   logic signed [PROD_W-1:0] prod_ff;
   acc_op_type               op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= ACC_NONE;
      end else begin
         op_ff <= acc_op;
      end
      prod_ff <= op_a * op_b;
   end

   assign prod    = prod_ff;
   assign prod_op = op_ff;

endmodule

// ===== design/rpnh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rpnh_div
   import rpnh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_stat_type       stat,
   output logic [NUM_W-1:0]   quo
);

   localparam int CW = $clog2(NUM_W);

   logic [NUM_W-1:0] q_ff,   q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem2;
   logic             ge;

   always_comb begin
      rem2    = {rem_ff, q_ff[NUM_W-1]};
      ge      = rem2 >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem2 - {1'b0, den_ff}) : rem2[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = q_ff;

endmodule

// ===== tb/ray_polygon_nearest_hit_tb.sv =====
// Testbench for the ray / polygon nearest-hit block: stream driver, receiver and scoreboard.
`timescale 1ns / 100ps

module ray_polygon_nearest_hit_tb;
   import rpnh_pkg::*;

   localparam int NVERT      = 64;
   localparam int RAND_ITEMS = 730;
   localparam int CALM_TAIL  = 100;   // last items sent with no idling
   localparam longint OUT_HI = 64'sd8388607;
   localparam longint OUT_LO = -64'sd8388608;

   typedef struct {
      logic         hit;
      logic [23:0]  hx;
      logic [23:0]  hy;
      logic         err;
   } hit_result_type;

   // Polygon state plus the queue of hit results still owed by the block.
   class hit_scoreboard;
      longint         vx[NVERT];
      longint         vy[NVERT];
      int             vcount;
      hit_result_type owed_q[$];
      int             errors;

      function new();
         vcount = 0;
         errors = 0;
      endfunction

      // start*256 + round(un*dir*256/den), ties toward +inf, then saturated
      function automatic logic [23:0] fixed_coord(longint start, longint un, longint den,
                                                  longint dir);
         bit [127:0] num;
         bit [127:0] q;
         bit         neg;
         longint     r;
         longint     v;
         neg = dir < 0;
         num = ({64'b0, un} << 8) * {64'b0, (neg ? -dir : dir)};
         num = (num << 1) + {64'b0, den} - (neg ? 128'd1 : 128'd0);
         q   = num / ({64'b0, den} << 1);
         if (q > (128'd1 << 40)) q = 128'd1 << 40;
         r = longint'(q[63:0]);
         v = start * 256 + (neg ? -r : r);
         if (v > OUT_HI) v = OUT_HI;
         if (v < OUT_LO) v = OUT_LO;
         return v[23:0];
      endfunction

      function automatic hit_result_type nearest_hit(longint px, longint py, longint ex,
                                                     longint ey);
         hit_result_type res;
         longint dx, dy, gx, gy, qx, qy, den, un, tn, best_un, best_den;
         bit found;
         int j;
         res = '{1'b0, 24'd0, 24'd0, 1'b0};
         dx = ex - px;
         dy = ey - py;
         found = 0;
         best_un = 0;
         best_den = 1;
         for (int i = 0; i < vcount; i++) begin
            j  = (i + 1 == vcount) ? 0 : i + 1;
            gx = vx[j] - vx[i];
            gy = vy[j] - vy[i];
            qx = vx[i] - px;
            qy = vy[i] - py;
            den = dx * gy - dy * gx;
            un  = qx * gy - qy * gx;
            tn  = qx * dy - qy * dx;
            if (den == 0) continue;
            if (den < 0) begin
               den = -den;
               un = -un;
               tn = -tn;
            end
            if (un < 0 || tn < 0 || tn > den) continue;
            // strict compare keeps the earlier edge on a tie
            if (!found || ({64'b0, un} * {64'b0, best_den} <
                           {64'b0, best_un} * {64'b0, den})) begin
               found = 1;
               best_un = un;
               best_den = den;
            end
         end
         if (found) begin
            res.hit = 1'b1;
            res.hx  = fixed_coord(px, best_un, best_den, dx);
            res.hy  = fixed_coord(py, best_un, best_den, dy);
         end
         return res;
      endfunction

      function void note_request(cmd_type op, logic [63:0] data);
         hit_result_type res;
         longint px, py, ex, ey;
         px = longint'($signed(data[15:0]));
         py = longint'($signed(data[31:16]));
         ex = longint'($signed(data[47:32]));
         ey = longint'($signed(data[63:48]));
         res = '{1'b0, 24'd0, 24'd0, 1'b0};
         case (op)
            CMD_APPEND: begin
               if (vcount >= NVERT) begin
                  res.err = 1'b1;
               end else begin
                  vx[vcount] = px;
                  vy[vcount] = py;
                  vcount++;
               end
            end
            CMD_REPLACE: begin
               if (vcount == 0) begin
                  res.err = 1'b1;
               end else begin
                  vx[vcount-1] = px;
                  vy[vcount-1] = py;
               end
            end
            CMD_CAST: res = nearest_hit(px, py, ex, ey);
            default: ;
         endcase
         owed_q = {owed_q, res};
      endfunction

      function void check_response(logic [47:0] data, logic [1:0] user);
         hit_result_type e;
         if (owed_q.size() == 0) begin
            $error("response with nothing outstanding: tdata=%h tuser=%b", data, user);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (user[0] !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, user[0]);
            errors++;
         end
         if (data[23:0] !== e.hx) begin
            $error("hit_x: expected %h, got %h", e.hx, data[23:0]);
            errors++;
         end
         if (data[47:24] !== e.hy) begin
            $error("hit_y: expected %h, got %h", e.hy, data[47:24]);
            errors++;
         end
         if (user[1] !== e.err) begin
            $error("op_error: expected %0d, got %0d", e.err, user[1]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // pt_x, pt_y, end_x, end_y
   logic [1:0]  req_tuser;    // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // hit_x, hit_y
   logic [1:0]  rsp_tuser;    // hit, op_error

   hit_scoreboard sb;
   bit  calm;
   int  rsp_seen = 0;

   ray_polygon_nearest_hit #(.MAX_VERTICES(NVERT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Verification failed");
      $finish;
   end

   // both channel monitors, sampled at the edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(cmd_type'(req_tuser), req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser);
         rsp_seen++;
      end
   end

   task automatic send(cmd_type op, int px, int py, int ex, int ey);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ey[15:0], ex[15:0], py[15:0], px[15:0]};
      do @(posedge clock); while (!req_tready);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // mostly near the polygon, sometimes anywhere in range
   function automatic int coord();
      case ($urandom_range(0, 9))
         0, 1:    return $signed(16'($urandom));
         2:       return $urandom_range(0, 1) ? 32767 : -32768;
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   // result receiver: random stalls, one long hold-off to back the block up
   initial begin
      int hold;
      bit held;
      held = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && rsp_seen >= 30 && rsp_tvalid) begin
            held = 1;
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int op_pick;
      sb = new();
      calm = 0;
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_NONE;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, degenerate polygons, then a square
      send(CMD_REPLACE, 5, 5, 0, 0);
      send(CMD_CAST, 0, 0, 10, 10);
      send(CMD_NONE, -1, -1, -1, -1);
      send(CMD_APPEND, 0, 0, 0, 0);
      send(CMD_CAST, -5, 0, 5, 0);
      send(CMD_APPEND, 100, 0, 0, 0);
      send(CMD_CAST, 50, -50, 50, 50);
      send(CMD_APPEND, 100, 100, 0, 0);
      send(CMD_APPEND, 0, 100, 0, 0);
      send(CMD_CAST, 50, 50, 150, 50);
      send(CMD_CAST, -10, 0, 0, 0);        // runs along an edge, hits a corner
      send(CMD_CAST, 50, 50, 50, 50);      // zero-length ray
      send(CMD_CAST, 50, 50, 100, 100);    // through a corner: tie between the edges that meet there
      send(CMD_CAST, -10, -10, -20, -20);  // pointing away
      send(CMD_CAST, 50, 50, 51, 53);      // rounding of a fractional hit
      send(CMD_CAST, 50, 50, 49, 47);
      send(CMD_REPLACE, 32767, -32768, 0, 0);
      send(CMD_CAST, -32768, 32767, 32767, -32768);
      send(CMD_CAST, 32767, 32767, -32768, -32768);
      send(CMD_APPEND, -32768, 32767, 0, 0);
      send(CMD_CAST, 0, 0, 1, 0);
      send(CMD_CAST, 0, 0, -1, 1);
      send(CMD_NONE, 32767, -32768, 32767, -32768);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - CALM_TAIL) calm = 1;
         op_pick = $urandom_range(0, 99);
         if (op_pick < 30)
            send(CMD_APPEND, coord(), coord(), $urandom, $urandom);
         else if (op_pick < 48)
            send(CMD_REPLACE, coord(), coord(), $urandom, $urandom);
         else if (op_pick < 95)
            send(CMD_CAST, coord(), coord(), coord(), coord());
         else
            send(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
      end
      req_tvalid <= 1'b0;

      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/rpnh_pkg.sv
design/rpnh_vstore.sv
design/rpnh_mul.sv
design/rpnh_div.sv
design/ray_polygon_nearest_hit.sv
tb/ray_polygon_nearest_hit_tb.sv
